// ----- sv/d9p_pkg.sv -----
// Shared types, codes and sizes for the DE-9IM predicate evaluator.
`default_nettype none

package d9p_pkg;

	// matrix geometry and pattern register layout
	localparam int unsigned N_CELLS   = 9;
	localparam int unsigned CELL_W    = 3;
	localparam int unsigned DIM_W     = 2;
	localparam int unsigned PATTERN_W = N_CELLS * CELL_W;

	// APB port sizes
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	// register index, taken from paddr[2]
	localparam logic REG_REQUIRED_PATTERN = 1'b0;

	// cell codes
	localparam logic [CELL_W-1:0] CELL_EMPTY    = 3'd0;
	localparam logic [CELL_W-1:0] CELL_POINT    = 3'd1;
	localparam logic [CELL_W-1:0] CELL_LINE     = 3'd2;
	localparam logic [CELL_W-1:0] CELL_AREA     = 3'd3;
	localparam logic [CELL_W-1:0] CELL_NONEMPTY = 3'd4;
	localparam logic [CELL_W-1:0] CELL_DONTCARE = 3'd5;

	// pattern symbol codes
	localparam logic [CELL_W-1:0] SYM_ANY = 3'd0;
	localparam logic [CELL_W-1:0] SYM_T   = 3'd1;
	localparam logic [CELL_W-1:0] SYM_F   = 3'd2;
	localparam logic [CELL_W-1:0] SYM_D0  = 3'd3;
	localparam logic [CELL_W-1:0] SYM_D1  = 3'd4;
	localparam logic [CELL_W-1:0] SYM_D2  = 3'd5;

	// geometry dimension codes
	localparam logic [DIM_W-1:0] DIM_POINT = 2'd0;
	localparam logic [DIM_W-1:0] DIM_LINE  = 2'd1;
	localparam logic [DIM_W-1:0] DIM_AREA  = 2'd2;
	localparam logic [DIM_W-1:0] DIM_BAD   = 2'd3;

	// one input item
	typedef struct packed {
		logic [CELL_W-1:0] cell_ii;
		logic [CELL_W-1:0] cell_ib;
		logic [CELL_W-1:0] cell_ie;
		logic [CELL_W-1:0] cell_bi;
		logic [CELL_W-1:0] cell_bb;
		logic [CELL_W-1:0] cell_be;
		logic [CELL_W-1:0] cell_ei;
		logic [CELL_W-1:0] cell_eb;
		logic [CELL_W-1:0] cell_ee;
		logic [DIM_W-1:0]  dim_a;
		logic [DIM_W-1:0]  dim_b;
	} matrix_t;

	// one result item
	typedef struct packed {
		logic is_disjoint;
		logic is_intersecting;
		logic is_touching;
		logic is_crossing;
		logic is_within;
		logic is_containing;
		logic is_equal;
		logic is_overlapping;
		logic is_covering;
		logic is_covered;
		logic pattern_hit;
	} predicates_t;

endpackage

`default_nettype wire

// ----- sv/d9p_stream_if.sv -----
// Valid/ready stream channel carrying one payload item per handshake.
`default_nettype none

interface d9p_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/d9p_eval.sv -----
// Combinational predicate and pattern evaluation for one matrix.
`default_nettype none

module d9p_eval (
	input  wire  d9p_pkg::matrix_t                    matrix,
	input  wire  logic [d9p_pkg::PATTERN_W-1:0]       pattern,
	output d9p_pkg::predicates_t                      preds
);

	// point, line, area or nonempty; dontcare and unused codes are not
	function automatic logic is_ne(input logic [d9p_pkg::CELL_W-1:0] c);
		return (c == d9p_pkg::CELL_POINT) || (c == d9p_pkg::CELL_LINE) ||
		       (c == d9p_pkg::CELL_AREA) || (c == d9p_pkg::CELL_NONEMPTY);
	endfunction

	function automatic logic is_em(input logic [d9p_pkg::CELL_W-1:0] c);
		return c == d9p_pkg::CELL_EMPTY;
	endfunction

	// one cell against one pattern symbol; unused symbols match nothing
	function automatic logic sym_ok(input logic [d9p_pkg::CELL_W-1:0] c,
	                                input logic [d9p_pkg::CELL_W-1:0] s);
		logic ok;
		case (s)
			d9p_pkg::SYM_ANY: ok = 1'b1;
			d9p_pkg::SYM_T:   ok = is_ne(c);
			d9p_pkg::SYM_F:   ok = (c == d9p_pkg::CELL_EMPTY);
			d9p_pkg::SYM_D0:  ok = (c == d9p_pkg::CELL_POINT);
			d9p_pkg::SYM_D1:  ok = (c == d9p_pkg::CELL_LINE);
			d9p_pkg::SYM_D2:  ok = (c == d9p_pkg::CELL_AREA);
			default:          ok = 1'b0;
		endcase
		return ok;
	endfunction

	logic [d9p_pkg::CELL_W-1:0] cells [d9p_pkg::N_CELLS];
	logic [d9p_pkg::N_CELLS-1:0] cell_hit;
	logic [d9p_pkg::DIM_W-1:0] da, db;
	logic dims_ok, disj, common;

	// row-major cell order, matching the pattern register layout
	assign cells[0] = matrix.cell_ii;
	assign cells[1] = matrix.cell_ib;
	assign cells[2] = matrix.cell_ie;
	assign cells[3] = matrix.cell_bi;
	assign cells[4] = matrix.cell_bb;
	assign cells[5] = matrix.cell_be;
	assign cells[6] = matrix.cell_ei;
	assign cells[7] = matrix.cell_eb;
	assign cells[8] = matrix.cell_ee;

	assign da = matrix.dim_a;
	assign db = matrix.dim_b;
	assign dims_ok = (da != d9p_pkg::DIM_BAD) && (db != d9p_pkg::DIM_BAD);

	// per-cell pattern match
	always_comb begin
		for (int k = 0; k < d9p_pkg::N_CELLS; k++) begin
			cell_hit[k] = sym_ok(cells[k], pattern[k*d9p_pkg::CELL_W +: d9p_pkg::CELL_W]);
		end
	end

	assign disj = is_em(matrix.cell_ii) && is_em(matrix.cell_ib) &&
	              is_em(matrix.cell_bi) && is_em(matrix.cell_bb);
	assign common = is_ne(matrix.cell_ii) || is_ne(matrix.cell_ib) ||
	                is_ne(matrix.cell_bi) || is_ne(matrix.cell_bb);

	// predicates
	always_comb begin
		preds.is_disjoint     = disj;
		preds.is_intersecting = !disj;

		// every valid pair except point/point
		preds.is_touching = dims_ok &&
		                    !((da == d9p_pkg::DIM_POINT) && (db == d9p_pkg::DIM_POINT)) &&
		                    is_em(matrix.cell_ii) &&
		                    (is_ne(matrix.cell_ib) || is_ne(matrix.cell_bi) ||
		                     is_ne(matrix.cell_bb));

		// lower-dimension A looks at ie, higher-dimension A at ei; equal lines need a point ii
		preds.is_crossing = 1'b0;
		if (dims_ok) begin
			if (da < db) begin
				preds.is_crossing = is_ne(matrix.cell_ii) && is_ne(matrix.cell_ie);
			end else if (da > db) begin
				preds.is_crossing = is_ne(matrix.cell_ii) && is_ne(matrix.cell_ei);
			end else if (da == d9p_pkg::DIM_LINE) begin
				preds.is_crossing = (matrix.cell_ii == d9p_pkg::CELL_POINT);
			end
		end

		preds.is_within = is_ne(matrix.cell_ii) && is_em(matrix.cell_ie) &&
		                  is_em(matrix.cell_be);
		preds.is_containing = is_ne(matrix.cell_ii) && is_em(matrix.cell_ei) &&
		                      is_em(matrix.cell_eb);
		preds.is_equal = (da == db) && is_ne(matrix.cell_ii) &&
		                 is_em(matrix.cell_ie) && is_em(matrix.cell_be) &&
		                 is_em(matrix.cell_ei) && is_em(matrix.cell_eb);

		// only for equal dimensions
		preds.is_overlapping = 1'b0;
		if (da == db) begin
			if ((da == d9p_pkg::DIM_POINT) || (da == d9p_pkg::DIM_AREA)) begin
				preds.is_overlapping = is_ne(matrix.cell_ii) && is_ne(matrix.cell_ie) &&
				                       is_ne(matrix.cell_ei);
			end else if (da == d9p_pkg::DIM_LINE) begin
				preds.is_overlapping = (matrix.cell_ii == d9p_pkg::CELL_LINE) &&
				                       is_ne(matrix.cell_ie) && is_ne(matrix.cell_ei);
			end
		end

		preds.is_covering = common && is_em(matrix.cell_ei) && is_em(matrix.cell_eb);
		preds.is_covered  = common && is_em(matrix.cell_ie) && is_em(matrix.cell_be);
		preds.pattern_hit = &cell_hit;
	end

endmodule

`default_nettype wire

// ----- sv/de9im_predicate_evaluator.sv -----
// Top level of the DE-9IM predicate evaluator: input/result registers and APB register.
//
// Usage:
//   in_ch  : sink stream of matrix items (nine cell codes plus both dimensions).
//   out_ch : source stream of predicate items, one per input item, in order.
//   APB    : one register, required_pattern, at byte address 0 (paddr[2] selects
//            the register; addresses with paddr[2] set read 0 and ignore writes).
//            Write it only while no item is in flight.
// Path: an accepted item goes through the input register, then the result register, to out_ch.
// Throughput: one item per cycle while out_ch.ready is high; the input register
//   and the result register each move whenever the stage after them is empty or
//   drains that cycle; the predicate logic between is a single pass of shallow gates.
// Stall: when out_ch.ready is low the result register holds; an empty input register
//   still takes one more item, after which in_ch.ready drops until out_ch drains.
// Reset: arst_n low clears both stage valid flags and sets required_pattern to 0.
`default_nettype none

module de9im_predicate_evaluator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	d9p_stream_if.sink                             in_ch,
	d9p_stream_if.source                           out_ch,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [d9p_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [d9p_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [d9p_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                   pready
);

	logic [d9p_pkg::PATTERN_W-1:0] pattern_q;
	logic                          valid_s1, valid_s2;
	logic                          ready_s1, ready_s2;
	d9p_pkg::matrix_t              matrix_s1;
	d9p_pkg::predicates_t          preds_c, preds_s2;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
		end else if (psel && penable && pwrite && pready &&
		             (paddr[2] == d9p_pkg::REG_REQUIRED_PATTERN)) begin
			pattern_q <= pwdata[d9p_pkg::PATTERN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == d9p_pkg::REG_REQUIRED_PATTERN) begin
			prdata[d9p_pkg::PATTERN_W-1:0] = pattern_q;
		end
	end

	// stage enables: a stage loads when it is empty or its contents move on
	assign ready_s2    = !valid_s2 || out_ch.ready;
	assign ready_s1    = !valid_s1 || ready_s2;
	assign in_ch.ready = ready_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_ch.valid) begin
			matrix_s1 <= in_ch.data;
		end
	end

	d9p_eval u_eval (
		.matrix  (matrix_s1),
		.pattern (pattern_q),
		.preds   (preds_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			preds_s2 <= preds_c;
		end
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.data  = preds_s2;

	// checks
	a_int_vs_disj: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (preds_s2.is_intersecting != preds_s2.is_disjoint))
		else $error("intersecting is not the complement of disjoint");

	a_equal_implies: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && preds_s2.is_equal) |->
		(preds_s2.is_within && preds_s2.is_containing &&
		 preds_s2.is_covering && preds_s2.is_covered))
		else $error("equal result without within/contains/covers/covered");

	a_touch_not_within: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && preds_s2.is_touching) |->
		(!preds_s2.is_within && !preds_s2.is_crossing && !preds_s2.is_overlapping))
		else $error("touching result conflicts with an interior predicate");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ready_s2) |=> (valid_s1 && $stable(matrix_s1)))
		else $error("input stage item lost while result stage stalled");

	a_s2_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ready_s2) |=> valid_s2)
		else $error("input stage item did not reach result stage");

endmodule

`default_nettype wire
